// ----- sv/icrle_pkg.sv -----
// ----------------------------------------------------------------------------
// icrle_pkg
// Shared types and constants for the icon run-length channel decoder.
// ----------------------------------------------------------------------------
package icrle_pkg;

	// Largest icon side handled; wider settings are clamped to it
	localparam int unsigned MAX_SIDE = 128;

	// Fixed field and state widths
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned SIDE_W  = 8;
	localparam int unsigned CHUNK_W = 17;
	localparam int unsigned PIX_W   = 14;
	localparam int unsigned PLANE_W = 15;
	localparam int unsigned LANE_W  = 2;

	// Side after reset and the plane size that goes with it
	localparam logic [SIDE_W-1:0]  SIDE_RESET  = 8'd16;
	localparam logic [PLANE_W-1:0] PLANE_RESET = 15'd256;

	// Control byte coding
	localparam logic [BYTE_W-1:0] REPEAT_MARK = 8'h80;
	localparam logic [BYTE_W-1:0] REPEAT_BIAS = 8'd125;

	// First colour plane goes to this lane, then counts down to lane zero
	localparam logic [LANE_W-1:0] LANE_FIRST = 2'd2;
	localparam logic [LANE_W-1:0] LANE_LAST  = 2'd0;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_ICON_SIDE   = 1'b0,
		REG_CHUNK_BYTES = 1'b1
	} reg_index_t;

	// Decoder phase, one-hot
	typedef enum logic [3:0] {
		PH_CTRL    = 4'b0001,
		PH_VALUE   = 4'b0010,
		PH_LITERAL = 4'b0100,
		PH_SKIP    = 4'b1000
	} phase_t;

endpackage

// ----- sv/icon_rle_channel_decoder_core.sv -----
// ----------------------------------------------------------------------------
// icon_rle_channel_decoder_core
// Turns a chunk of icon bytes, run-length coded or raw, into run descriptors
// for the colour planes of a 4-byte pixel image.
// ----------------------------------------------------------------------------
// Data path: input register, then result register, with one decode pass
// in between them from input word to result word.
// Throughput: one input word per cycle while a held result is not stalled;
// the decode counters update in a single pass, so a word may then follow in every cycle.
// Reset: clears all decode state, icon_side returns to 16, chunk_bytes to 0,
// and words before the first chunk start are dropped.
// ----------------------------------------------------------------------------
module icon_rle_channel_decoder_core #(
	parameter int unsigned MAX_SIDE = icrle_pkg::MAX_SIDE
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [icrle_pkg::CHUNK_W-1:0]   cfg_data,

	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [icrle_pkg::BYTE_W-1:0]    data_byte,
	input  logic                            chunk_start,

	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [icrle_pkg::BYTE_W-1:0]    pixel_value,
	output logic [icrle_pkg::LANE_W-1:0]    byte_lane,
	output logic [icrle_pkg::PIX_W-1:0]     first_pixel,
	output logic [icrle_pkg::BYTE_W-1:0]    run_length,
	output logic                            chunk_done,
	output logic                            overrun_error
);

	localparam int unsigned BW = icrle_pkg::BYTE_W;
	localparam int unsigned CW = icrle_pkg::CHUNK_W;
	localparam int unsigned PW = icrle_pkg::PIX_W;
	localparam int unsigned QW = icrle_pkg::PLANE_W;
	localparam int unsigned LW = icrle_pkg::LANE_W;
	localparam logic [icrle_pkg::SIDE_W-1:0] SIDE_CAP = icrle_pkg::SIDE_W'(MAX_SIDE);

	// Configuration registers and the clamped, squared side
	logic [CW-1:0]                chunk_bytes_q;
	logic [QW-1:0]                plane_q;
	logic [icrle_pkg::SIDE_W-1:0] side_clamp;
	logic [2*icrle_pkg::SIDE_W-1:0] side_sq;

	// Decode state
	icrle_pkg::phase_t phase_q;
	logic [BW-1:0]     literal_left_q;
	logic [BW-1:0]     repeat_count_q;
	logic [LW-1:0]     lane_q;
	logic [QW-1:0]     remaining_q;
	logic [PW-1:0]     position_q;
	logic [CW-1:0]     raw_count_q;
	logic              finished_q;

	// Input stage
	logic          valid_s1;
	logic [BW-1:0] data_s1;
	logic          start_s1;

	// Decode pass signals
	icrle_pkg::phase_t phase_e, phase_n;
	logic [BW-1:0]     literal_e, literal_n, literal_dec;
	logic [BW-1:0]     repeat_e, repeat_n;
	logic [LW-1:0]     lane_e, lane_n;
	logic [QW-1:0]     remaining_e, remaining_n, rem_after;
	logic [PW-1:0]     position_e, position_n;
	logic [CW-1:0]     raw_e, raw_n;
	logic              finished_e, finished_n;
	logic [QW-1:0]     run_c;
	logic              adv_c, adv_done, raw_mode;
	logic [CW:0]       raw_next;
	logic              res_c;
	logic [BW-1:0]     res_value;
	logic [LW-1:0]     res_lane;
	logic [PW-1:0]     res_first;
	logic [BW-1:0]     res_len;
	logic              res_done, res_ovr;
	logic              fire_s1;

	assign cfg_ready = 1'b1;

	// Clamp the side and square it for the plane size held with the setting
	assign side_clamp = (cfg_data[icrle_pkg::SIDE_W-1:0] > SIDE_CAP) ?
		SIDE_CAP : cfg_data[icrle_pkg::SIDE_W-1:0];
	assign side_sq = side_clamp * side_clamp;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q <= '0;
			plane_q       <= icrle_pkg::PLANE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				icrle_pkg::REG_ICON_SIDE: begin
					plane_q <= QW'(side_sq);
				end
				icrle_pkg::REG_CHUNK_BYTES: begin
					chunk_bytes_q <= cfg_data;
				end
				default: begin
					plane_q <= plane_q;
				end
			endcase
		end
	end

	// Hold the input word until the decode pass can use it
	assign fire_s1    = valid_s1 && (!res_c || !result_valid || result_ready);
	assign item_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			data_s1  <= data_byte;
			start_s1 <= chunk_start;
		end
	end

	// Decode pass: restart on chunk start, then one step of the decoder
	always_comb begin
		phase_e     = start_s1 ? icrle_pkg::PH_CTRL : phase_q;
		literal_e   = start_s1 ? '0 : literal_left_q;
		repeat_e    = start_s1 ? '0 : repeat_count_q;
		lane_e      = start_s1 ? icrle_pkg::LANE_FIRST : lane_q;
		remaining_e = start_s1 ? plane_q : remaining_q;
		position_e  = start_s1 ? '0 : position_q;
		raw_e       = start_s1 ? '0 : raw_count_q;
		finished_e  = start_s1 ? (plane_q == '0) : finished_q;

		raw_mode    = (chunk_bytes_q == {plane_q, 2'b00});
		raw_next    = {1'b0, raw_e} + (CW+1)'(1);
		literal_dec = (literal_e != '0) ? literal_e - BW'(1) : '0;

		// Pick the run that this step advances by
		adv_c   = 1'b0;
		run_c   = QW'(1);
		res_ovr = 1'b0;
		if (phase_e == icrle_pkg::PH_VALUE) begin
			adv_c = 1'b1;
			if (QW'(repeat_e) > remaining_e) begin
				run_c   = remaining_e;
				res_ovr = 1'b1;
			end else begin
				run_c = QW'(repeat_e);
			end
		end else if (phase_e == icrle_pkg::PH_LITERAL) begin
			adv_c = 1'b1;
		end

		// Advance through the plane, switching lane or finishing at its end
		rem_after = remaining_e - run_c;
		adv_done  = (rem_after == '0) && ((lane_e == icrle_pkg::LANE_LAST) || (plane_q == '0));

		phase_n     = phase_e;
		literal_n   = literal_e;
		repeat_n    = repeat_e;
		lane_n      = lane_e;
		remaining_n = remaining_e;
		position_n  = position_e;
		raw_n       = raw_e;
		finished_n  = finished_e;

		res_c     = 1'b0;
		res_value = data_s1;
		res_lane  = lane_e;
		res_first = position_e;
		res_len   = BW'(run_c);
		res_done  = 1'b0;

		if (finished_e) begin
			res_c   = 1'b0;
			res_ovr = 1'b0;
		end else if (raw_mode) begin
			// Pass the byte through as a single-pixel run
			res_c      = 1'b1;
			res_ovr    = 1'b0;
			res_lane   = raw_e[LW-1:0];
			res_first  = raw_e[PW+LW-1:LW];
			res_len    = BW'(1);
			res_done   = (raw_next >= {1'b0, chunk_bytes_q});
			raw_n      = raw_next[CW-1:0];
			finished_n = res_done;
		end else begin
			if (adv_c) begin
				res_c      = 1'b1;
				res_done   = adv_done;
				position_n = position_e + PW'(run_c);
				remaining_n = rem_after;
				if (adv_done) begin
					finished_n = 1'b1;
				end else if (rem_after == '0) begin
					lane_n      = lane_e - LW'(1);
					remaining_n = plane_q;
					position_n  = '0;
				end
			end
			case (phase_e)
				icrle_pkg::PH_CTRL: begin
					if (data_s1 >= icrle_pkg::REPEAT_MARK) begin
						repeat_n = data_s1 - icrle_pkg::REPEAT_BIAS;
						phase_n  = icrle_pkg::PH_VALUE;
					end else begin
						literal_n = data_s1 + BW'(1);
						phase_n   = icrle_pkg::PH_LITERAL;
					end
				end
				icrle_pkg::PH_VALUE: begin
					phase_n = icrle_pkg::PH_CTRL;
				end
				icrle_pkg::PH_LITERAL: begin
					literal_n = literal_dec;
					res_ovr   = (rem_after == '0) && (literal_dec != '0);
					if (literal_dec == '0) begin
						phase_n = icrle_pkg::PH_CTRL;
					end else if (res_ovr) begin
						phase_n = icrle_pkg::PH_SKIP;
					end
				end
				icrle_pkg::PH_SKIP: begin
					literal_n = literal_dec;
					if (literal_dec == '0) begin
						phase_n = icrle_pkg::PH_CTRL;
					end
				end
				default: begin
					phase_n = icrle_pkg::PH_CTRL;
				end
			endcase
		end
	end

	// Commit the decode state when the input word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= icrle_pkg::PH_CTRL;
			literal_left_q <= '0;
			repeat_count_q <= '0;
			lane_q         <= icrle_pkg::LANE_FIRST;
			remaining_q    <= '0;
			position_q     <= '0;
			raw_count_q    <= '0;
			finished_q     <= 1'b1;
		end else if (fire_s1) begin
			phase_q        <= phase_n;
			literal_left_q <= literal_n;
			repeat_count_q <= repeat_n;
			lane_q         <= lane_n;
			remaining_q    <= remaining_n;
			position_q     <= position_n;
			raw_count_q    <= raw_n;
			finished_q     <= finished_n;
		end
	end

	// Result register: load a new descriptor or drop the one taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (fire_s1 && res_c) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_c) begin
			pixel_value   <= res_value;
			byte_lane     <= res_lane;
			first_pixel   <= res_first;
			run_length    <= res_len;
			chunk_done    <= res_done;
			overrun_error <= res_ovr;
		end
	end

endmodule
